// ===== sv/jfhd_pkg.sv =====
// Shared constants and the binary16 field helpers for the joint frame decoder.
// No dependencies.
`default_nettype none
package jfhd_pkg;
  localparam int JOINTS = 7;
  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic [7:0] BASE_ID_RESET = 8'd21;
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_PUBLISH = 1'b1;
  localparam logic [4:0] HALF_EXP_MAX = 5'h1F;
  localparam logic [7:0] EXP_BIAS_DIFF = 8'd112;
  localparam logic [7:0] SUB_EXP_BASE = 8'd103;
endpackage
`default_nettype wire

// ===== sv/joint_frame_half_float_decoder.sv =====
// Top level of the joint frame decoder: frame intake, shared half-to-single
// converter, joint stores and publish sequencer. Depends on jfhd_pkg.
`default_nettype none
// Channel   | handshake              | payload
// ----------+------------------------+-------------------------------------------
// command   | start / busy           | operation, frame_id, three halves
// config    | cfg_valid / cfg_ready  | cfg_data (base_id)
// result    | strobe (one cycle)     | joint_number, three singles, last_joint
//
// Sequence: a joint frame keeps busy high through one converter state per half,
// then a write of the joint's stores; a publish keeps busy high while it reads
// all JOINTS joints, one result word per cycle, each word on the ports the cycle
// after it is read. The shared converter sets the frame rate.
// Reset clears the stores to +0.0 and base_id to 21. The receiver cannot stall.
module joint_frame_half_float_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation,
  input  wire logic [7:0]  frame_id,
  input  wire logic [15:0] position_half,
  input  wire logic [15:0] velocity_half,
  input  wire logic [15:0] effort_half,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  output logic             strobe,
  output logic [3:0]       joint_number,
  output logic [31:0]      position_single,
  output logic [31:0]      velocity_single,
  output logic [31:0]      effort_single,
  output logic             last_joint
);
  import jfhd_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_POS, S_VEL, S_EFF, S_WRITE, S_PUB} state_t;
  state_t state;

  logic [7:0]  base_id;
  logic [15:0] vel_h, eff_h, pos_h;
  logic [JW-1:0] jsel;
  logic        hit;
  logic [31:0] pos_w, vel_w, eff_w;
  logic [31:0] pos_st [JOINTS];
  logic [31:0] vel_st [JOINTS];
  logic [31:0] eff_st [JOINTS];
  logic [JW-1:0] pidx;

  // shared converter
  logic [15:0] cv_in;
  logic [31:0] cv_out;
  logic [4:0]  cv_ex;
  logic [9:0]  cv_sig;
  logic [3:0]  cv_p;
  logic [9:0]  cv_norm;
  logic        cv_nan;

  logic [8:0]  id_off;
  logic        in_win;

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign id_off = {1'b0, frame_id} - {1'b0, base_id};
  assign in_win = !id_off[8] && (id_off < 9'(JOINTS));

  always_comb begin
    case (state)
      S_VEL:   cv_in = vel_h;
      S_EFF:   cv_in = eff_h;
      default: cv_in = pos_h;
    endcase
    cv_ex = cv_in[14:10];
    cv_sig = cv_in[9:0];
    cv_p = 4'd0;
    for (int k = 0; k < 10; k++) begin
      if (cv_sig[k]) cv_p = 4'(k);
    end
    cv_norm = cv_sig << (4'd10 - cv_p);
    if (cv_ex == 5'd0) begin
      if (cv_sig == 10'd0) cv_out = {cv_in[15], 31'd0};
      else cv_out = {cv_in[15], SUB_EXP_BASE + 8'(cv_p), cv_norm, 13'd0};
    end else if (cv_ex == HALF_EXP_MAX) begin
      cv_out = {cv_in[15], 8'hFF, cv_sig, 13'd0};
    end else begin
      cv_out = {cv_in[15], EXP_BIAS_DIFF + 8'(cv_ex), cv_sig, 13'd0};
    end
    cv_nan = (cv_ex == HALF_EXP_MAX) && (cv_sig != 10'd0);
  end

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      base_id <= BASE_ID_RESET;
      for (int i = 0; i < JOINTS; i++) begin
        pos_st[i] <= '0;
        vel_st[i] <= '0;
        eff_st[i] <= '0;
      end
      pidx <= '0;
      last_joint <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) base_id <= cfg_data;
          if (start) begin
            pidx <= '0;
            if (operation == OP_PUBLISH) state <= S_PUB;
            else begin
              state <= S_POS;
              hit <= in_win;
              jsel <= JW'(id_off);
              pos_h <= position_half;
              vel_h <= velocity_half;
              eff_h <= effort_half;
            end
          end
        end
        S_POS: begin
          pos_w <= cv_nan ? 32'd0 : cv_out;
          state <= S_VEL;
        end
        S_VEL: begin
          vel_w <= cv_out;
          state <= S_EFF;
        end
        S_EFF: begin
          eff_w <= cv_out;
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (hit) begin
            pos_st[jsel] <= pos_w;
            vel_st[jsel] <= vel_w;
            eff_st[jsel] <= eff_w;
          end
          state <= S_IDLE;
        end
        S_PUB: begin
          strobe <= 1'b1;
          joint_number <= 4'(pidx);
          position_single <= pos_st[pidx];
          velocity_single <= vel_st[pidx];
          effort_single <= eff_st[pidx];
          last_joint <= (pidx == JW'(JOINTS - 1));
          if (pidx == JW'(JOINTS - 1)) state <= S_IDLE;
          else pidx <= pidx + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_joint) |-> !busy)
    else $error("last joint word while still publishing");
  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    ($rose(strobe)) |-> (joint_number == 4'd0))
    else $error("publish run did not start at joint zero");
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cfg_ready)
    else $error("config accepted while busy");
`endif
endmodule
`default_nettype wire
